### rtl/msq_pkg.sv
`default_nettype none
package msq_pkg;

  localparam int unsigned MELODY_LEN = 12;
  localparam int unsigned PHASE_BITS = 32;

  localparam int unsigned RATE_W    = 18;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned LEN_W     = 10;
  localparam int unsigned PERIOD_W  = LEN_W + 1;
  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned NOTE_W    = 4;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned AMP_W     = 15;
  localparam int unsigned FREQ_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = RATE_W;
  localparam int unsigned CNT_W     =
    $clog2((PHASE_BITS > ELAPSED_W) ? PHASE_BITS : ELAPSED_W);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LEN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN     = 2'd3;

  localparam logic [RATE_W-1:0]  RATE_RESET   = 18'd16000;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 7'd50;
  localparam logic [LEN_W-1:0]   NOTE_RESET   = 10'd180;
  localparam logic [LEN_W-1:0]   GAP_RESET    = 10'd40;
  localparam logic [RATE_W-1:0]  DEFAULT_RATE = 18'd16000;
  localparam logic [RATE_W-1:0]  FREQ_FLOOR   = 18'd40;
  localparam logic [AMP_W-1:0]   FULL_SCALE   = 15'd32767;
  localparam logic [AMP_W-1:0]   AMP_FLOOR    = 15'd200;

  // level * 32767 / 100 through a reciprocal: ceil(2^29 / 100)
  localparam int unsigned   SCALED_W  = LEVEL_W + AMP_W;
  localparam int unsigned   RECIP_W   = 23;
  localparam int unsigned   RECIP_SH  = 29;
  localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;

  typedef struct packed {
    logic load;
    logic idx_step;
    logic step_start;
    logic step_step;
    logic commit;
  } msq_cmd_t;

  typedef struct packed {
    logic need_load;
  } msq_status_t;

  function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    unique case (idx)
      4'd1, 4'd4, 4'd7, 4'd10: f = 10'd587;
      4'd2, 4'd8:              f = 10'd659;
      default:                 f = 10'd523;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

### rtl/msq_ctrl.sv
`default_nettype none
module msq_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  input  wire msq_pkg::msq_status_t   status_i,
  output msq_pkg::msq_cmd_t           cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_IDX  = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [msq_pkg::CNT_W-1:0] IDX_LAST  = msq_pkg::CNT_W'(msq_pkg::ELAPSED_W - 1);
  localparam logic [msq_pkg::CNT_W-1:0] STEP_LAST = msq_pkg::CNT_W'(msq_pkg::PHASE_BITS - 1);

  logic [1:0]                state_q, state_d;
  logic [msq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      ovalid_q, ovalid_d;
  logic                      accept;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_IDX;
        end
      end
      S_IDX: begin
        cmd_o.idx_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == IDX_LAST) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end
      end
      S_STEP: begin
        cmd_o.step_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.need_load && cnt_q == '0) begin
          // first pass through: start the increment division
          cmd_o.step_start = 1'b1;
          cnt_d            = '0;
          state_d          = S_STEP;
        end else if (!ovalid_q || m_axis_tready) begin
          cmd_o.commit = 1'b1;
          ovalid_d     = 1'b1;
          cnt_d        = '0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_STEP && cnt_q == STEP_LAST) begin
      // mark the increment as done so the output state goes on to commit
      cnt_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!ovalid_q || m_axis_tready))
    else $error("result overwritten before it was taken");

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_IDX && cnt_q == '0))
    else $error("accepted word did not start the index division");

  a_idx_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDX) |-> (cnt_q <= IDX_LAST))
    else $error("index division ran past its last step");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

endmodule
`default_nettype wire

### rtl/msq_dpath.sv
`default_nettype none
module msq_dpath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [msq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [msq_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire                                 restart_i,
  input  wire  [msq_pkg::ELAPSED_W-1:0]       elapsed_i,
  input  wire msq_pkg::msq_cmd_t              cmd_i,
  output msq_pkg::msq_status_t                status_o,
  output logic [msq_pkg::SAMPLE_W-1:0]        sample_o,
  output logic                                muted_o,
  output logic [msq_pkg::NOTE_W-1:0]          note_o,
  output logic                                done_o
);

  localparam int unsigned EW = msq_pkg::ELAPSED_W;
  localparam int unsigned PW = msq_pkg::PERIOD_W;
  localparam int unsigned RW = msq_pkg::RATE_W;
  localparam int unsigned PB = msq_pkg::PHASE_BITS;
  localparam int unsigned NW = msq_pkg::NOTE_W;
  localparam int unsigned QW = msq_pkg::SCALED_W + msq_pkg::RECIP_W - msq_pkg::RECIP_SH;

  // configuration
  logic [RW-1:0]                    rate_q;
  logic [msq_pkg::LEVEL_W-1:0]      level_q;
  logic [msq_pkg::LEN_W-1:0]        note_len_q, gap_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= msq_pkg::RATE_RESET;
      level_q    <= msq_pkg::LEVEL_RESET;
      note_len_q <= msq_pkg::NOTE_RESET;
      gap_len_q  <= msq_pkg::GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msq_pkg::REG_SAMPLE_RATE: rate_q     <= cfg_data_i[RW-1:0];
        msq_pkg::REG_LEVEL:       level_q    <= cfg_data_i[msq_pkg::LEVEL_W-1:0];
        msq_pkg::REG_NOTE_LEN:    note_len_q <= cfg_data_i[msq_pkg::LEN_W-1:0];
        msq_pkg::REG_GAP_LEN:     gap_len_q  <= cfg_data_i[msq_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // amplitude
  logic [msq_pkg::SCALED_W-1:0]                   scaled;
  logic [msq_pkg::SCALED_W+msq_pkg::RECIP_W-1:0]  prod;
  logic [QW-1:0]                                  quot;
  logic [msq_pkg::AMP_W-1:0]                      amp_d, amp_q;

  assign scaled = (msq_pkg::SCALED_W'(level_q) << msq_pkg::AMP_W) - msq_pkg::SCALED_W'(level_q);
  assign prod   = (msq_pkg::SCALED_W+msq_pkg::RECIP_W)'(scaled)
                * (msq_pkg::SCALED_W+msq_pkg::RECIP_W)'(msq_pkg::RECIP_100);
  assign quot   = prod[msq_pkg::SCALED_W+msq_pkg::RECIP_W-1:msq_pkg::RECIP_SH];

  always_comb begin
    if (quot > QW'(msq_pkg::FULL_SCALE)) begin
      amp_d = msq_pkg::FULL_SCALE;
    end else if (quot < QW'(msq_pkg::AMP_FLOOR)) begin
      amp_d = msq_pkg::AMP_FLOOR;
    end else begin
      amp_d = quot[msq_pkg::AMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    amp_q <= amp_d;
  end

  // input word and note index divider
  logic          restart_q;
  logic [EW-1:0] dq_q, dq_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [PW-1:0] period;
  logic [PW:0]   itrial;
  logic          ige;

  assign period = PW'(note_len_q) + PW'(gap_len_q);
  assign itrial = {rem_q, dq_q[EW-1]};
  assign ige    = (itrial >= {1'b0, period});

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      dq_d  = elapsed_i;
      rem_d = '0;
    end else if (cmd_i.idx_step) begin
      dq_d  = {dq_q[EW-2:0], ige};
      rem_d = ige ? PW'(itrial - {1'b0, period}) : itrial[PW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      restart_q <= restart_i;
    end
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  // architectural state
  logic [PB-1:0] phase_q, step_q;
  logic [NW-1:0] cur_q;
  logic          gmute_q;

  logic [EW-1:0] idx;
  logic [PW-1:0] offs;
  logic          done, chg, gmute_n;
  logic [NW-1:0] cur_eff, cur_n, load_note;
  logic [PB-1:0] phase_eff, step_eff, phase_n;

  assign idx       = (period == '0) ? '0 : dq_q;
  assign offs      = (period == '0) ? '0 : rem_q;
  assign done      = (idx >= EW'(msq_pkg::MELODY_LEN));
  assign cur_eff   = restart_q ? '0 : cur_q;
  assign chg       = !done && (idx != EW'(cur_eff));
  assign load_note = chg ? idx[NW-1:0] : '0;
  assign cur_n     = chg ? idx[NW-1:0] : cur_eff;
  assign gmute_n   = done ? (gmute_q && !restart_q)
                          : (offs >= PW'(note_len_q));
  assign status_o.need_load = chg || restart_q;

  // phase increment divider: (freq << PB) / rate, one quotient bit per cycle
  logic [RW-1:0] rate_eff, freq, rem2_q, rem2_d;
  logic [RW:0]   strial;
  logic          sge;
  logic [PB-1:0] q2_q, q2_d;

  assign rate_eff = (rate_q == '0) ? msq_pkg::DEFAULT_RATE : rate_q;

  always_comb begin
    freq = RW'(msq_pkg::note_freq(load_note));
    if (freq < msq_pkg::FREQ_FLOOR) begin
      freq = msq_pkg::FREQ_FLOOR;
    end
    if (freq >= (rate_eff >> 1)) begin
      freq = rate_eff >> 2;
    end
  end

  assign strial = {rem2_q, 1'b0};
  assign sge    = (strial >= {1'b0, rate_eff});

  always_comb begin
    rem2_d = rem2_q;
    q2_d   = q2_q;
    if (cmd_i.step_start) begin
      rem2_d = freq;
      q2_d   = '0;
    end else if (cmd_i.step_step) begin
      rem2_d = sge ? RW'(strial - {1'b0, rate_eff}) : strial[RW-1:0];
      q2_d   = {q2_q[PB-2:0], sge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem2_q <= rem2_d;
    q2_q   <= q2_d;
  end

  assign step_eff  = status_o.need_load ? ((q2_q == '0) ? PB'(1) : q2_q) : step_q;
  assign phase_eff = restart_q ? '0 : phase_q;
  assign phase_n   = phase_eff + step_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      cur_q   <= '0;
      gmute_q <= 1'b0;
    end else if (cmd_i.commit) begin
      phase_q <= phase_n;
      step_q  <= step_eff;
      cur_q   <= cur_n;
      gmute_q <= gmute_n;
    end
  end

  // output word
  logic [msq_pkg::SAMPLE_W-1:0] amp_ext, sample_n;

  assign amp_ext = msq_pkg::SAMPLE_W'(amp_q);

  always_comb begin
    if (gmute_n) begin
      sample_n = '0;
    end else if (phase_n[PB-1]) begin
      sample_n = amp_ext;
    end else begin
      sample_n = msq_pkg::SAMPLE_W'(0) - amp_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      sample_o <= sample_n;
      muted_o  <= gmute_n;
      note_o   <= cur_n;
      done_o   <= done;
    end
  end

endmodule
`default_nettype wire

### rtl/melody_square_tone_generator.sv
// channel  | dir | tdata (low bit up)                      | tuser (low bit up)
// s_axis   | in  | elapsed time[19:0], zero pad to 24      | restart
// m_axis   | out | sample[15:0], note_number[19:16], pad   | muted, melody_done
// cfg      | in  | 0 sample rate, 1 level, 2 note length, 3 gap length
//
// one word at a time: restoring division finds the note and the offset in the note
// period, plus a second division for the phase increment on a note change or restart
// the next word is taken while a finished result waits in the output register
// reset restores register defaults and clears phase, increment, note and mute
`default_nettype none
module melody_square_tone_generator (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [23:0]                         s_axis_tdata,  // elapsed time in ms
  input  wire  [0:0]                          s_axis_tuser,  // restart
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [23:0]                         m_axis_tdata,  // sample, note_number
  output logic [1:0]                          m_axis_tuser,  // muted, melody_done
  input  wire                                 cfg_we_i,
  input  wire  [msq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [msq_pkg::CFG_W-1:0]           cfg_data_i
);

  msq_pkg::msq_cmd_t             cmd;
  msq_pkg::msq_status_t          status;
  logic [msq_pkg::SAMPLE_W-1:0]  sample;
  logic [msq_pkg::NOTE_W-1:0]    note;
  logic                          muted, done;

  msq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  msq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .restart_i  (s_axis_tuser[0]),
    .elapsed_i  (s_axis_tdata[msq_pkg::ELAPSED_W-1:0]),
    .cmd_i      (cmd),
    .status_o   (status),
    .sample_o   (sample),
    .muted_o    (muted),
    .note_o     (note),
    .done_o     (done)
  );

  assign m_axis_tdata = {4'b0, note, sample};
  assign m_axis_tuser = {done, muted};

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS   = 1225;
  localparam int unsigned LONG_HOLD      = 600;

  typedef struct packed {
    logic [15:0] sample;
    logic        muted;
    logic [3:0]  note;
    logic        done;
  } tone_word_t;

  class tone_scoreboard;
    logic [17:0] rate_hz;
    logic [6:0]  level_pct;
    logic [9:0]  note_ms;
    logic [9:0]  gap_ms;
    logic [31:0] phase_acc;
    logic [31:0] phase_inc;
    logic [3:0]  cur_note;
    logic        gap_mute;
    tone_word_t  pending_tones[$];
    int unsigned fails;
    int unsigned seen;

    function new();
      rate_hz   = msq_pkg::RATE_RESET;
      level_pct = msq_pkg::LEVEL_RESET;
      note_ms   = msq_pkg::NOTE_RESET;
      gap_ms    = msq_pkg::GAP_RESET;
      phase_acc = '0;
      phase_inc = '0;
      cur_note  = '0;
      gap_mute  = 1'b0;
      fails     = 0;
      seen      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [17:0] val);
      case (idx)
        msq_pkg::REG_SAMPLE_RATE: rate_hz   = val;
        msq_pkg::REG_LEVEL:       level_pct = val[6:0];
        msq_pkg::REG_NOTE_LEN:    note_ms   = val[9:0];
        msq_pkg::REG_GAP_LEN:     gap_ms    = val[9:0];
        default: ;
      endcase
    endfunction

    // phase increment for one melody note at the current rate
    function logic [31:0] step_for(logic [3:0] idx);
      logic [63:0] rate;
      logic [63:0] freq;
      logic [63:0] inc;
      rate = (rate_hz == 18'd0) ? 64'd16000 : {46'd0, rate_hz};
      case (idx)
        4'd1, 4'd4, 4'd7, 4'd10: freq = 64'd587;
        4'd2, 4'd8:              freq = 64'd659;
        default:                 freq = 64'd523;
      endcase
      if (freq < 64'd40) freq = 64'd40;
      if (freq >= rate / 64'd2) freq = rate / 64'd4;
      inc = (freq << 32) / rate;
      if (inc[31:0] == 32'd0) inc = 64'd1;
      return inc[31:0];
    endfunction

    function void note_word(logic rs, logic [19:0] el);
      logic [19:0] period;
      logic [19:0] idx;
      logic [19:0] offs;
      logic        done;
      int unsigned amp;
      tone_word_t  w;
      period = {10'd0, note_ms} + {10'd0, gap_ms};
      if (rs) begin
        phase_acc = '0;
        cur_note  = '0;
        gap_mute  = 1'b0;
        phase_inc = step_for(4'd0);
      end
      idx  = '0;
      offs = '0;
      if (period != 20'd0) begin
        idx  = el / period;
        offs = el % period;
      end
      done = (idx >= 20'(msq_pkg::MELODY_LEN));
      if (!done) begin
        if (idx != {16'd0, cur_note}) begin
          cur_note  = idx[3:0];
          phase_inc = step_for(cur_note);
        end
        gap_mute = (offs >= {10'd0, note_ms});
      end
      amp = (32'd32767 * {25'd0, level_pct}) / 32'd100;
      if (amp > 32'd32767) amp = 32'd32767;
      if (amp < 32'd200) amp = 32'd200;
      if (gap_mute) amp = 32'd0;
      phase_acc = phase_acc + phase_inc;
      w.sample = phase_acc[31] ? 16'(amp) : 16'(32'd0 - amp);
      w.muted  = gap_mute;
      w.note   = cur_note;
      w.done   = done;
      pending_tones.push_back(w);
    endfunction

    function void check_word(logic [23:0] td, logic [1:0] tu);
      tone_word_t e;
      seen++;
      if (pending_tones.size() == 0) begin
        $error("unexpected word: tdata %h tuser %b", td, tu);
        fails++;
        return;
      end
      e = pending_tones.pop_front();
      if (td[15:0] !== e.sample) begin
        $error("sample: expected %0d, actual %0d", $signed(e.sample), $signed(td[15:0]));
        fails++;
      end
      if (td[19:16] !== e.note) begin
        $error("note_number: expected %0d, actual %0d", e.note, td[19:16]);
        fails++;
      end
      if (tu[0] !== e.muted) begin
        $error("muted: expected %0d, actual %0d", e.muted, tu[0]);
        fails++;
      end
      if (tu[1] !== e.done) begin
        $error("melody_done: expected %0d, actual %0d", e.done, tu[1]);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return pending_tones.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // elapsed time in ms, zero pad
  logic [0:0]  s_axis_tuser;   // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // sample, note_number, zero pad
  logic [1:0]  m_axis_tuser;   // muted, melody_done
  logic        cfg_we_i;
  logic [msq_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [msq_pkg::CFG_W-1:0]     cfg_data_i;

  tone_scoreboard sb;
  int unsigned    burst_left;
  int unsigned    idle_cycles;

  melody_square_tone_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // offer one word, after a random gap when the current burst is used up
  task automatic offer(input logic rs, input logic [19:0] el);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, el};
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(rs, el);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [17:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(input logic [17:0] rate, input logic [6:0] level,
                              input logic [9:0] note, input logic [9:0] gap);
    drain();
    write_cfg(msq_pkg::REG_SAMPLE_RATE, rate);
    write_cfg(msq_pkg::REG_LEVEL, {11'd0, level});
    write_cfg(msq_pkg::REG_NOTE_LEN, {8'd0, note});
    write_cfg(msq_pkg::REG_GAP_LEN, {8'd0, gap});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("melody_square_tone_generator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: changing stall modes, plus one long hold-off to back up the block
  initial begin : receiver
    int unsigned cyc;
    int unsigned mode;
    logic        held;
    logic [15:0] pat;
    m_axis_tready = 1'b0;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    pat  = 16'b1011_0011_1110_0101;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && sb.seen >= 300) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (cyc % 200 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= pat[cyc % 16];
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
      cyc++;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    int unsigned period;
    int unsigned step_max;
    int unsigned cursor;
    logic        restart_due;
    logic [17:0] rate;
    logic [6:0]  level;
    logic [9:0]  note;
    logic [9:0]  gap;
    sb            = new();
    burst_left    = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: phase frozen before any restart, note edges, gap, done
    offer(1'b0, 20'd0);
    offer(1'b0, 20'd5);
    offer(1'b0, 20'd300);
    offer(1'b1, 20'd0);
    offer(1'b0, 20'd179);
    offer(1'b0, 20'd180);
    offer(1'b0, 20'd219);
    offer(1'b0, 20'd220);
    offer(1'b0, 20'd2639);
    offer(1'b0, 20'd2640);
    offer(1'b0, 20'hFFFFF);
    offer(1'b1, 20'hFFFFF);

    // zero rate, zero level, zero period
    apply_config(18'd0, 7'd0, 10'd0, 10'd0);
    offer(1'b1, 20'd0);
    offer(1'b0, 20'hFFFFF);

    // rate of one, saturated level, longest note and gap
    apply_config(18'd1, 7'd127, 10'd1023, 10'd1023);
    offer(1'b1, 20'd1023);
    offer(1'b0, 20'd2046);
    offer(1'b0, 20'd24551);
    offer(1'b0, 20'd24552);

    // top rate, one ms notes with no gap
    apply_config(18'h3FFFF, 7'd100, 10'd1, 10'd0);
    offer(1'b1, 20'd0);
    offer(1'b0, 20'd11);
    offer(1'b0, 20'd12);

    // half rate clamp on the highest note, note length zero
    apply_config(18'd1318, 7'd1, 10'd0, 10'd5);
    offer(1'b1, 20'd0);
    offer(1'b0, 20'd10);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       rate = 18'd0;
        1:       rate = 18'd1;
        2:       rate = 18'h3FFFF;
        3:       rate = 18'($urandom_range(1, 2000));
        4:       rate = 18'($urandom);
        default: rate = 18'($urandom_range(1000, 192000));
      endcase
      case ($urandom_range(0, 5))
        0:       level = 7'd0;
        1:       level = 7'd100;
        2:       level = 7'd127;
        default: level = 7'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 7))
        0:       note = 10'd0;
        1:       note = 10'd1023;
        2:       note = 10'($urandom_range(0, 1023));
        default: note = 10'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 7))
        0, 1:    gap = 10'd0;
        2:       gap = 10'd1023;
        3:       gap = 10'($urandom_range(0, 1023));
        default: gap = 10'($urandom_range(1, 20));
      endcase
      apply_config(rate, level, note, gap);
      period      = int'(note) + int'(gap);
      step_max    = period / 4 + 1;
      cursor      = 0;
      restart_due = 1'b1;
      n           = $urandom_range(60, 120);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          offer(1'($urandom_range(0, 1)), 20'($urandom));
        end else if (restart_due || pick < 16) begin
          cursor      = $urandom_range(0, period);
          restart_due = 1'b0;
          offer(1'b1, 20'(cursor));
        end else begin
          cursor = cursor + $urandom_range(0, step_max);
          offer(1'b0, 20'(cursor));
          if (cursor > 13 * period + 1) restart_due = 1'b1;
        end
        sent++;
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("melody_square_tone_generator test passed");
    end else begin
      $display("melody_square_tone_generator test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/msq_pkg.sv
rtl/msq_ctrl.sv
rtl/msq_dpath.sv
rtl/melody_square_tone_generator.sv
tb/tb_top.sv
